// ===== sv/tog_pkg.sv =====
`timescale 1ns / 1ps
// shared constants, control structs and the character map for the id generator
// no dependencies

package tog_pkg;

    localparam int TIME_DIGITS   = 8;
    localparam int SUFFIX_DIGITS = 12;
    localparam int TOTAL_CHARS   = TIME_DIGITS + SUFFIX_DIGITS;
    localparam int DIGIT_W       = 6;
    localparam int TIME_W        = 48;
    localparam int RAND_W        = 72;
    localparam int CHAR_W        = 7;
    localparam int POS_W         = $clog2(TOTAL_CHARS);
    localparam int CNT_W         = $clog2(TOTAL_CHARS + 1);

    localparam logic [DIGIT_W-1:0] DIGIT_MAX = '1;

    // control for one cell of the output chain
    typedef struct packed {
        logic load;
        logic shift;
    } chain_ctrl_t;

    // control for one cell of the stored suffix
    typedef struct packed {
        logic load_rand;
        logic bump;
    } sfx_ctrl_t;

    // digit to ascii through the 64-symbol alphabet
    function automatic logic [CHAR_W-1:0] digit_to_char(input logic [DIGIT_W-1:0] digit);
        logic [CHAR_W-1:0] ch;
        case (digit) inside
            6'd0:          ch = 7'd45;
            [6'd1:6'd10]:  ch = 7'(7'd47 + 7'(digit));
            [6'd11:6'd36]: ch = 7'(7'd54 + 7'(digit));
            6'd37:         ch = 7'd95;
            default:       ch = 7'(7'd59 + 7'(digit));
        endcase
        return ch;
    endfunction

endpackage

// ===== sv/time_ordered_id_generator.sv =====
`timescale 1ns / 1ps
// top level of the time-ordered id generator: suffix store, output chain, output register
// depends on tog_pkg, tog_cell, tog_sfx_cell

// Each transaction on the input side produces a 20-character identifier, sent one
// character per transaction on the output side with its position and a last flag.
// The characters sit in a chain of 20 digit cells that shifts one place per cycle
// toward an output register while that register is not held by a stall, and a new
// input is taken in the cycle that the last character leaves the chain. The stored
// suffix digits are updated in the cycle of acceptance, from the random bits on a
// new timestamp or by a 72-bit increment on a repeated one.

module time_ordered_id_generator (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [tog_pkg::TIME_W-1:0]          now_time,
    input  logic [63:0]                         random_low,
    input  logic [7:0]                          random_high,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [tog_pkg::CHAR_W-1:0]          id_char,
    output logic [tog_pkg::POS_W-1:0]           char_position,
    output logic                                last_char
);

    localparam int TD = tog_pkg::TIME_DIGITS;
    localparam int SD = tog_pkg::SUFFIX_DIGITS;
    localparam int TC = tog_pkg::TOTAL_CHARS;
    localparam int DW = tog_pkg::DIGIT_W;

    logic [tog_pkg::TIME_W-1:0] prev_time_reg;
    logic [tog_pkg::CNT_W-1:0]  cnt_reg, cnt_next;
    logic [tog_pkg::POS_W-1:0]  pos_reg, pos_next;
    logic                       out_valid_reg, out_valid_next;
    logic [tog_pkg::CHAR_W-1:0] char_reg, char_next;
    logic [tog_pkg::POS_W-1:0]  opos_reg, opos_next;
    logic                       last_reg, last_next;

    logic                       move;
    logic                       in_take;
    logic                       is_repeat;
    logic [tog_pkg::RAND_W-1:0] rnd;

    logic [DW-1:0] load_digit [TC];
    logic [DW-1:0] chain_digit [TC];
    logic [SD:0]   carry;

    tog_pkg::chain_ctrl_t chain_ctrl;
    tog_pkg::sfx_ctrl_t   sfx_ctrl;

    assign move      = (cnt_reg != '0) && (!out_valid_reg || !out_stall);
    assign in_stall  = !((cnt_reg == '0) || ((cnt_reg == tog_pkg::CNT_W'(1)) && move));
    assign in_take   = in_valid && !in_stall;
    assign is_repeat = (now_time == prev_time_reg);
    assign rnd       = {random_high, random_low};

    assign chain_ctrl.load  = in_take;
    assign chain_ctrl.shift = move;
    assign sfx_ctrl.load_rand = in_take && !is_repeat;
    assign sfx_ctrl.bump      = in_take && is_repeat;

    // least significant suffix digit always gets the +1
    assign carry[SD] = 1'b1;

    genvar gi;
    generate
        for (gi = 0; gi < TD; gi++)
        begin : g_time
            assign load_digit[gi] = DW'(now_time >> (DW * (TD - 1 - gi)));
        end

        for (gi = 0; gi < SD; gi++)
        begin : g_sfx
            tog_sfx_cell u_sfx (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (sfx_ctrl),
                .rand_digit (DW'(rnd >> (DW * (SD - 1 - gi)))),
                .carry_in   (carry[gi+1]),
                .carry_out  (carry[gi]),
                .digit_upd  (load_digit[TD+gi])
            );
        end

        for (gi = 0; gi < TC; gi++)
        begin : g_chain
            logic [DW-1:0] nb;
            if (gi == TC - 1)
            begin : g_end
                assign nb = '0;
            end
            else
            begin : g_mid
                assign nb = chain_digit[gi+1];
            end
            tog_cell u_cell (
                .clk            (clk),
                .ctrl           (chain_ctrl),
                .load_digit     (load_digit[gi]),
                .neighbor_digit (nb),
                .digit          (chain_digit[gi])
            );
        end
    endgenerate

    always_comb
    begin
        cnt_next       = cnt_reg;
        pos_next       = pos_reg;
        out_valid_next = out_valid_reg && out_stall;
        char_next      = char_reg;
        opos_next      = opos_reg;
        last_next      = last_reg;
        if (move)
        begin
            out_valid_next = 1'b1;
            char_next      = tog_pkg::digit_to_char(chain_digit[0]);
            opos_next      = pos_reg;
            last_next      = (pos_reg == tog_pkg::POS_W'(TC - 1));
            cnt_next       = cnt_reg - tog_pkg::CNT_W'(1);
            pos_next       = pos_reg + tog_pkg::POS_W'(1);
        end
        if (in_take)
        begin
            cnt_next = tog_pkg::CNT_W'(TC);
            pos_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_time_reg <= '0;
            cnt_reg       <= '0;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_take)
            begin
                prev_time_reg <= now_time;
            end
            cnt_reg       <= cnt_next;
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        char_reg <= char_next;
        opos_reg <= opos_next;
        last_reg <= last_next;
    end

    assign out_valid     = out_valid_reg;
    assign id_char       = char_reg;
    assign char_position = opos_reg;
    assign last_char     = last_reg;

endmodule

// ===== sv/tog_cell.sv =====
`timescale 1ns / 1ps
// one cell of the output chain: holds a digit, loads in parallel, shifts toward the head
// depends on tog_pkg

module tog_cell (
    input  logic                         clk,
    input  tog_pkg::chain_ctrl_t         ctrl,
    input  logic [tog_pkg::DIGIT_W-1:0]  load_digit,
    input  logic [tog_pkg::DIGIT_W-1:0]  neighbor_digit,
    output logic [tog_pkg::DIGIT_W-1:0]  digit
);

    logic [tog_pkg::DIGIT_W-1:0] digit_reg;
    logic [tog_pkg::DIGIT_W-1:0] digit_next;

    always_comb
    begin
        digit_next = digit_reg;
        if (ctrl.load)
        begin
            digit_next = load_digit;
        end
        else if (ctrl.shift)
        begin
            digit_next = neighbor_digit;
        end
    end

    always_ff @(posedge clk)
    begin
        digit_reg <= digit_next;
    end

    assign digit = digit_reg;

endmodule

// ===== sv/tog_sfx_cell.sv =====
`timescale 1ns / 1ps
// one stored suffix digit: random load or increment with carry from the next lower digit
// depends on tog_pkg

module tog_sfx_cell (
    input  logic                         clk,
    input  logic                         rst_n,
    input  tog_pkg::sfx_ctrl_t           ctrl,
    input  logic [tog_pkg::DIGIT_W-1:0]  rand_digit,
    input  logic                         carry_in,
    output logic                         carry_out,
    output logic [tog_pkg::DIGIT_W-1:0]  digit_upd
);

    logic [tog_pkg::DIGIT_W-1:0] digit_reg;
    logic [tog_pkg::DIGIT_W-1:0] digit_next;

    assign carry_out = carry_in && (digit_reg == tog_pkg::DIGIT_MAX);

    always_comb
    begin
        digit_next = digit_reg;
        if (ctrl.load_rand)
        begin
            digit_next = rand_digit;
        end
        else if (ctrl.bump && carry_in)
        begin
            digit_next = digit_reg + tog_pkg::DIGIT_W'(1);
        end
    end

    // the updated value goes straight into the output chain
    assign digit_upd = digit_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            digit_reg <= '0;
        end
        else
        begin
            digit_reg <= digit_next;
        end
    end

endmodule

// ===== sv/tog_checker.sv =====
`timescale 1ns / 1ps
// port-level checks for the id generator, bound to the top level
// depends on tog_pkg and time_ordered_id_generator

module tog_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_stall,
    input logic                         out_valid,
    input logic                         out_stall,
    input logic [tog_pkg::CHAR_W-1:0]   id_char,
    input logic [tog_pkg::POS_W-1:0]    char_position,
    input logic                         last_char
);

    // a stalled character holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(id_char) &&
        $stable(char_position) && $stable(last_char))
        else $error("stalled output changed");

    // last flag marks exactly the final position
    a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (last_char == (char_position == tog_pkg::POS_W'(tog_pkg::TOTAL_CHARS - 1))))
        else $error("last_char does not match position");

    // inside an identifier the next character follows in the next cycle
    a_next_char: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last_char |=>
        out_valid && (char_position == $past(char_position) + tog_pkg::POS_W'(1)))
        else $error("gap or skip inside identifier");

    // a new input is not taken while an identifier is still in the chain
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken right after acceptance");

    a_char_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (id_char >= tog_pkg::CHAR_W'(45)) && (id_char <= tog_pkg::CHAR_W'(122)))
        else $error("character outside alphabet range");

endmodule

bind time_ordered_id_generator tog_checker u_tog_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .id_char       (id_char),
    .char_position (char_position),
    .last_char     (last_char)
);
